/* rtl/ptlsq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and solve micro-program of the plane translation solver.
package ptlsq_pkg;

	localparam int WIDE_W    = 232;   // holds every cofactor, determinant and scaled numerator
	localparam int SUM_W     = 64;
	localparam int NSUM      = 9;
	localparam int NWREG     = 10;
	localparam int NUOP      = 24;
	localparam int MUL_STEPS = 64;
	localparam int DIV_STEPS = 34;
	localparam int NUM_SHIFT = 14;
	localparam int DEN_SHIFT = 33;
	localparam int WFRAC     = 16;

	typedef logic [3:0] ridx_t;

	// Accumulator indexes
	localparam ridx_t IDX_HXX = 4'd0;
	localparam ridx_t IDX_HXY = 4'd1;
	localparam ridx_t IDX_HXZ = 4'd2;
	localparam ridx_t IDX_HYY = 4'd3;
	localparam ridx_t IDX_HYZ = 4'd4;
	localparam ridx_t IDX_HZZ = 4'd5;
	localparam ridx_t IDX_GX  = 4'd6;
	localparam ridx_t IDX_GY  = 4'd7;
	localparam ridx_t IDX_GZ  = 4'd8;

	// Wide working register indexes
	localparam ridx_t W_C00 = 4'd0;
	localparam ridx_t W_C01 = 4'd1;
	localparam ridx_t W_C02 = 4'd2;
	localparam ridx_t W_C11 = 4'd3;
	localparam ridx_t W_C12 = 4'd4;
	localparam ridx_t W_C22 = 4'd5;
	localparam ridx_t W_DET = 4'd6;
	localparam ridx_t W_NX  = 4'd7;
	localparam ridx_t W_NY  = 4'd8;
	localparam ridx_t W_NZ  = 4'd9;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] dist_first;
		logic signed [31:0] dist_second;
		logic        [31:0] corr_weight;
		logic               last_item;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
		logic               singular;
	} out_item_t;

	typedef struct packed {
		logic issuing;
		logic busy;
	} acc_status_t;

	typedef struct packed {
		logic  mc_wide;   // multiplicand from a wide register, else from a sum
		ridx_t mc_idx;
		ridx_t mp_idx;    // multiplier is always a sum
		logic  sub;
		logic  first;
		logic  last;
		ridx_t dst;
	} uop_t;

	function automatic uop_t uop_at(input logic [4:0] i);
		uop_t r;
		r = '0;
		unique case (i)
			5'd0:  r = '{1'b0, IDX_HYY, IDX_HZZ, 1'b0, 1'b1, 1'b0, W_C00};
			5'd1:  r = '{1'b0, IDX_HYZ, IDX_HYZ, 1'b1, 1'b0, 1'b1, W_C00};
			5'd2:  r = '{1'b0, IDX_HXZ, IDX_HYZ, 1'b0, 1'b1, 1'b0, W_C01};
			5'd3:  r = '{1'b0, IDX_HXY, IDX_HZZ, 1'b1, 1'b0, 1'b1, W_C01};
			5'd4:  r = '{1'b0, IDX_HXY, IDX_HYZ, 1'b0, 1'b1, 1'b0, W_C02};
			5'd5:  r = '{1'b0, IDX_HXZ, IDX_HYY, 1'b1, 1'b0, 1'b1, W_C02};
			5'd6:  r = '{1'b0, IDX_HXX, IDX_HZZ, 1'b0, 1'b1, 1'b0, W_C11};
			5'd7:  r = '{1'b0, IDX_HXZ, IDX_HXZ, 1'b1, 1'b0, 1'b1, W_C11};
			5'd8:  r = '{1'b0, IDX_HXY, IDX_HXZ, 1'b0, 1'b1, 1'b0, W_C12};
			5'd9:  r = '{1'b0, IDX_HXX, IDX_HYZ, 1'b1, 1'b0, 1'b1, W_C12};
			5'd10: r = '{1'b0, IDX_HXX, IDX_HYY, 1'b0, 1'b1, 1'b0, W_C22};
			5'd11: r = '{1'b0, IDX_HXY, IDX_HXY, 1'b1, 1'b0, 1'b1, W_C22};
			5'd12: r = '{1'b1, W_C00, IDX_HXX, 1'b0, 1'b1, 1'b0, W_DET};
			5'd13: r = '{1'b1, W_C01, IDX_HXY, 1'b0, 1'b0, 1'b0, W_DET};
			5'd14: r = '{1'b1, W_C02, IDX_HXZ, 1'b0, 1'b0, 1'b1, W_DET};
			5'd15: r = '{1'b1, W_C00, IDX_GX, 1'b0, 1'b1, 1'b0, W_NX};
			5'd16: r = '{1'b1, W_C01, IDX_GY, 1'b0, 1'b0, 1'b0, W_NX};
			5'd17: r = '{1'b1, W_C02, IDX_GZ, 1'b0, 1'b0, 1'b1, W_NX};
			5'd18: r = '{1'b1, W_C01, IDX_GX, 1'b0, 1'b1, 1'b0, W_NY};
			5'd19: r = '{1'b1, W_C11, IDX_GY, 1'b0, 1'b0, 1'b0, W_NY};
			5'd20: r = '{1'b1, W_C12, IDX_GZ, 1'b0, 1'b0, 1'b1, W_NY};
			5'd21: r = '{1'b1, W_C02, IDX_GX, 1'b0, 1'b1, 1'b0, W_NZ};
			5'd22: r = '{1'b1, W_C12, IDX_GY, 1'b0, 1'b0, 1'b0, W_NZ};
			5'd23: r = '{1'b1, W_C22, IDX_GZ, 1'b0, 1'b0, 1'b1, W_NZ};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/ptlsq_addsub.sv */
`timescale 1ns / 1ps
// Wide add/subtract unit shared by all solve arithmetic: products, scaling and division.
module ptlsq_addsub import ptlsq_pkg::*; (
	input  logic [WIDE_W-1:0] x,
	input  logic [WIDE_W-1:0] y,
	input  logic              sub,
	output logic [WIDE_W-1:0] res
);

	assign res = x + (sub ? ~y : y) + {{(WIDE_W-1){1'b0}}, sub};

endmodule

/* rtl/ptlsq_accum.sv */
`timescale 1ns / 1ps
// Correspondence accumulation: one product per cycle into the nine saturating sums.
module ptlsq_accum import ptlsq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  in_item_t                item,
	input  logic                    use_weight,
	input  logic                    clear,
	input  ridx_t                   rd_idx,
	output logic signed [SUM_W-1:0] rd_data,
	output acc_status_t             status
);

	localparam ridx_t TERM_LAST = IDX_GZ;

	logic signed [15:0] nx_q, ny_q, nz_q;
	logic signed [32:0] diff_q;
	logic [31:0]        w_q;
	logic               wt_q;
	logic               act_q;
	ridx_t              cnt_q;

	logic signed [15:0] a_op;
	logic signed [32:0] b_op;

	logic               v_s1, v_s2, v_s3, v_s4;
	ridx_t              idx_s1, idx_s2, idx_s3, idx_s4;
	logic               wt_s1, wt_s2, wt_s3;
	logic [31:0]        w_s1, w_s2;
	logic signed [48:0] p_s1;
	logic [47:0]        mag_s2;
	logic               neg_s2, neg_s3;
	logic [SUM_W-1:0]   raw_s2, raw_s3;
	logic [SUM_W-1:0]   hi_s3, lo_s3;
	logic [SUM_W-1:0]   val_s4;

	logic signed [SUM_W-1:0] sum_q [NSUM];

	logic [48:0]        mag49;
	logic [SUM_W-1:0]   wres;
	ridx_t              sidx;
	logic [SUM_W-1:0]   cur;
	logic [SUM_W:0]     ext_sum;
	logic [SUM_W-1:0]   sat_sum;

	// operand pick for the term being issued
	always_comb begin
		case (cnt_q) inside
			IDX_HXX, IDX_HXY, IDX_HXZ, IDX_GX: a_op = nx_q;
			IDX_HYY, IDX_HYZ, IDX_GY:          a_op = ny_q;
			default:                           a_op = nz_q;
		endcase
		case (cnt_q) inside
			IDX_HXX:                   b_op = {{17{nx_q[15]}}, nx_q};
			IDX_HXY, IDX_HYY:          b_op = {{17{ny_q[15]}}, ny_q};
			IDX_HXZ, IDX_HYZ, IDX_HZZ: b_op = {{17{nz_q[15]}}, nz_q};
			default:                   b_op = diff_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				if (cnt_q == TERM_LAST) begin
					act_q <= 1'b0;
				end
				cnt_q <= cnt_q + 4'd1;
			end
			v_s1 <= act_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// item capture and product pipeline
	always_ff @(posedge clk) begin
		if (start) begin
			nx_q   <= item.normal_x;
			ny_q   <= item.normal_y;
			nz_q   <= item.normal_z;
			diff_q <= {item.dist_second[31], item.dist_second}
				- {item.dist_first[31], item.dist_first};
			w_q    <= item.corr_weight;
			wt_q   <= use_weight;
		end
		p_s1   <= a_op * b_op;
		idx_s1 <= cnt_q;
		wt_s1  <= wt_q;
		w_s1   <= w_q;

		neg_s2 <= p_s1[48];
		mag_s2 <= mag49[47:0];
		raw_s2 <= {{(SUM_W-49){p_s1[48]}}, p_s1};
		idx_s2 <= idx_s1;
		wt_s2  <= wt_s1;
		w_s2   <= w_s1;

		hi_s3  <= {16'b0, mag_s2} * {48'b0, w_s2[31:16]};
		lo_s3  <= {16'b0, mag_s2} * {48'b0, w_s2[15:0]};
		neg_s3 <= neg_s2;
		raw_s3 <= raw_s2;
		idx_s3 <= idx_s2;
		wt_s3  <= wt_s2;

		val_s4 <= wt_s3 ? (neg_s3 ? (~wres + 64'd1) : wres) : raw_s3;
		idx_s4 <= idx_s3;
	end

	assign mag49 = p_s1[48] ? (~p_s1 + 49'd1) : p_s1;
	assign wres  = hi_s3 + (lo_s3 >> WFRAC);

	// one read port: the accumulate stage while it writes a sum, the solver otherwise
	assign sidx    = v_s4 ? idx_s4 : rd_idx;
	assign cur     = sum_q[sidx];
	assign rd_data = sum_q[sidx];
	assign ext_sum = {cur[SUM_W-1], cur} + {val_s4[SUM_W-1], val_s4};

	always_comb begin
		if (ext_sum[SUM_W] != ext_sum[SUM_W-1]) begin
			sat_sum = ext_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_sum = ext_sum[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSUM; i++) sum_q[i] <= '0;
		end else if (clear) begin
			for (int i = 0; i < NSUM; i++) sum_q[i] <= '0;
		end else if (v_s4) begin
			sum_q[idx_s4] <= sat_sum;
		end
	end

	assign status.issuing = act_q;
	assign status.busy    = act_q | v_s1 | v_s2 | v_s3 | v_s4;

endmodule

/* rtl/ptlsq_solver.sv */
`timescale 1ns / 1ps
// Sequencer for the adjugate solve: shift-add products and restoring division on one adder.
module ptlsq_solver import ptlsq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] sum_rd,
	output ridx_t                   rd_idx,
	input  logic                    take,
	output logic                    res_valid,
	output out_item_t               res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LDA  = 4'd1;
	localparam logic [3:0] S_LDB  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_DNUM = 4'd5;
	localparam logic [3:0] S_DDEN = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_DSAT = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	localparam logic [4:0] UOP_LAST = 5'(NUOP - 1);
	localparam logic [5:0] MUL_LAST = 6'(MUL_STEPS - 1);
	localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);
	localparam logic [1:0] AXIS_LAST = 2'd2;

	logic [3:0]  state_q;
	logic [4:0]  uop_q;
	logic [5:0]  bit_q;
	logic [1:0]  axis_q;

	logic [WIDE_W-1:0] wreg_q [NWREG];
	logic [WIDE_W-1:0] acc_q, mcand_q, rem_q, dv_q;
	logic [SUM_W-1:0]  mplr_q;
	logic [DIV_STEPS-1:0] q_q;
	logic              negn_q, neg_q, sing_q;
	logic [31:0]       trans_q [3];

	uop_t              uop;
	ridx_t             wrd_idx;
	logic [WIDE_W-1:0] wrd, det, sum_ext;
	logic [WIDE_W-1:0] ax, ay, ares;
	logic              asub;
	logic              det_zero;
	logic [31:0]       sat;

	assign uop      = uop_at(uop_q);
	assign wrd_idx  = (state_q == S_DNUM) ? (W_NX + {2'b00, axis_q}) : uop.mc_idx;
	assign wrd      = wreg_q[wrd_idx];
	assign det      = wreg_q[W_DET];
	assign det_zero = (det == '0);
	assign sum_ext  = {{(WIDE_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd};
	assign rd_idx   = (state_q == S_LDB) ? uop.mp_idx : uop.mc_idx;

	always_comb begin
		ax   = '0;
		ay   = '0;
		asub = 1'b0;
		unique case (state_q)
			S_MUL: begin
				ax   = acc_q;
				ay   = mplr_q[0] ? mcand_q : '0;
				asub = uop.sub ^ (bit_q == MUL_LAST);   // sign bit of the multiplier weighs -2^63
			end
			S_DNUM: begin
				ay   = wrd << NUM_SHIFT;
				asub = wrd[WIDE_W-1];
			end
			S_DDEN: begin
				ay   = det << DEN_SHIFT;
				asub = det[WIDE_W-1];
			end
			S_DIV: begin
				ax   = rem_q;
				ay   = dv_q;
				asub = 1'b1;
			end
			default: begin
				ax   = '0;
			end
		endcase
	end

	ptlsq_addsub u_addsub (
		.x   (ax),
		.y   (ay),
		.sub (asub),
		.res (ares)
	);

	always_comb begin
		if (neg_q) begin
			sat = (q_q > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(34'd0 - q_q);
		end else begin
			sat = (q_q > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			uop_q   <= '0;
			bit_q   <= '0;
			axis_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					uop_q   <= '0;
					state_q <= S_LDA;
				end
				S_LDA: state_q <= S_LDB;
				S_LDB: begin
					bit_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == MUL_LAST) begin
						if (uop_q == UOP_LAST) begin
							state_q <= S_CHK;
						end else begin
							uop_q   <= uop_q + 5'd1;
							state_q <= S_LDA;
						end
					end
				end
				S_CHK: begin
					axis_q  <= '0;
					state_q <= det_zero ? S_DONE : S_DNUM;
				end
				S_DNUM: state_q <= S_DDEN;
				S_DDEN: begin
					bit_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					bit_q <= bit_q + 6'd1;
					if (bit_q == DIV_LAST) state_q <= S_DSAT;
				end
				S_DSAT: begin
					if (axis_q == AXIS_LAST) begin
						state_q <= S_DONE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_DNUM;
					end
				end
				S_DONE: if (take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LDA: begin
				mcand_q <= uop.mc_wide ? wrd : sum_ext;
				if (uop.first) acc_q <= '0;
			end
			S_LDB: mplr_q <= sum_rd;
			S_MUL: begin
				acc_q   <= ares;
				mcand_q <= mcand_q << 1;
				mplr_q  <= mplr_q >> 1;
				if (bit_q == MUL_LAST && uop.last) wreg_q[uop.dst] <= ares;
			end
			S_CHK: begin
				sing_q <= det_zero;
				if (det_zero) begin
					trans_q[0] <= '0;
					trans_q[1] <= '0;
					trans_q[2] <= '0;
				end
			end
			S_DNUM: begin
				rem_q  <= ares;
				negn_q <= wrd[WIDE_W-1];
			end
			S_DDEN: begin
				dv_q  <= ares;
				neg_q <= negn_q ^ det[WIDE_W-1];
				q_q   <= '0;
			end
			S_DIV: begin
				if (!ares[WIDE_W-1]) begin
					rem_q <= ares;
					q_q   <= {q_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					q_q   <= {q_q[DIV_STEPS-2:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
			S_DSAT: trans_q[axis_q] <= sat;
			default: begin
			end
		endcase
	end

	assign res_valid    = (state_q == S_DONE);
	assign res.trans_x  = trans_q[0];
	assign res.trans_y  = trans_q[1];
	assign res.trans_z  = trans_q[2];
	assign res.singular = sing_q;

endmodule

/* rtl/plane_translation_lsq_solver_core.sv */
`timescale 1ns / 1ps
// Top level of the plane translation least-squares solver.
// Plane correspondences arrive one transaction at a time on the in_* channel. Each one
// adds its normal outer product and normal-times-distance-difference, weighted when
// use_weight is set, into nine saturating 64-bit sums, one product per cycle through a
// shared multiply pipeline; in_ready stays low while the item's products are issued. An
// item with last_item set also waits for that pipeline to drain and then runs the solve
// on one shared 232-bit adder: 24 shift-add products for the cofactors, determinant and
// numerators, then three restoring divisions (the singular case skips the divisions). The
// result sits in an output register, so the next correspondence is taken while out_valid
// waits for out_ready. After every solve the sums are cleared. use_weight is written via
// cfg_we/cfg_wdata; the user must do so only while the block is idle (not enforced).
module plane_translation_lsq_solver_core import ptlsq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_SOLVE = 2'd3;

	logic [1:0]  state_q;
	logic        use_weight_q;
	logic        last_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_fire;
	logic        sol_start;
	logic        take;
	logic        res_valid;
	logic        load_res;
	out_item_t   res;
	acc_status_t acc_st;
	ridx_t       rd_idx;
	logic signed [SUM_W-1:0] sum_rd;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign sol_start = (state_q == ST_DRAIN) & ~acc_st.busy;
	// free the output slot or hand over in the same cycle it is taken
	assign take      = ~out_valid_q | out_ready;
	assign load_res  = res_valid & take;

	// hold the mode register; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_weight_q <= 1'b0;
		end else if (cfg_we) begin
			use_weight_q <= cfg_wdata;
		end
	end

	// control: issue terms, drain on the last item, then wait for the solve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					last_q  <= in_item.last_item;
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: if (!acc_st.issuing) begin
					state_q <= last_q ? ST_DRAIN : ST_IDLE;
				end
				ST_DRAIN: if (sol_start) state_q <= ST_SOLVE;
				ST_SOLVE: if (load_res) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ptlsq_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_fire),
		.item       (in_item),
		.use_weight (use_weight_q),
		.clear      (load_res),
		.rd_idx     (rd_idx),
		.rd_data    (sum_rd),
		.status     (acc_st)
	);

	ptlsq_solver u_solver (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sol_start),
		.sum_rd    (sum_rd),
		.rd_idx    (rd_idx),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register: advance on load, drop valid once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef ASSERT_OFF
	a_result_from_solve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_SOLVE)
		else $error("result appeared without a solve");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.singular) |->
			(out_q.trans_x == 0 && out_q.trans_y == 0 && out_q.trans_z == 0))
		else $error("singular result carries a nonzero translation");

	a_solve_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SOLVE |-> !acc_st.busy)
		else $error("accumulation active during solve");

	a_no_accept_in_solve: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_fire)
		else $error("input taken while a result is pending in the solver");
`endif

endmodule
